// File: src/ple_pkg.sv
// Shared types, codes and constants for the positional list engine.
package ple_pkg;

  // Default list depth
  localparam int CAPACITY_DEF = 16;

  // Fixed field widths
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int REQ_W     = 2;
  localparam int CNT_OUT_W = 5;

  // Width that holds any position or count for compares (CAPACITY up to 256)
  localparam int CMP_W = 9;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_INS_WR,
    ST_READ
  } state_t;

endpackage

// File: src/positional_list_engine.sv
// Top level of the positional list engine: sequencer plus entry RAM.
//
// Usage: drive req_type, position and write_data with start high; the word
// is taken at a clock edge where start is high and busy is low. One result
// word follows each request, shown for exactly one cycle with done high:
// status, read_data, read_valid, item_count and is_empty. The receiver cannot
// stall; results must be taken when done is high.
// Steps from the accept edge to the result:
//   failed request or delete of the last entry: done is set at the accept edge
//   read: through ST_READ (registered RAM read)
//   insert: one ST_MOVE_RD/ST_MOVE_WR pair per later entry, then ST_INS_WR
//   delete with later entries: one ST_MOVE_RD/ST_MOVE_WR pair per later entry
// Each entry move costs a RAM read and a RAM write through the single
// read/write port pair; busy falls in the cycle the result is shown, so the
// next request may be accepted then. Reset clears the count and the sequencer;
// RAM contents are not cleared, and only slots below the count are ever read.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ple_pkg::REQ_W-1:0]        req_type,
  input  logic [ple_pkg::POS_W-1:0]        position,
  input  logic [ple_pkg::DATA_W-1:0]       write_data,
  output logic                             done,
  output logic                             status,
  output logic [ple_pkg::DATA_W-1:0]       read_data,
  output logic                             read_valid,
  output logic [ple_pkg::CNT_OUT_W-1:0]    item_count,
  output logic                             is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ple_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ple_pkg::DATA_W-1:0] ram_rdata;
  logic [CW-1:0]              count;

  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .position   (position),
    .write_data (write_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .done       (done),
    .status     (status),
    .read_data  (read_data),
    .read_valid (read_valid),
    .count      (count)
  );

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Report the count masked to the result field width
  assign item_count = ple_pkg::CNT_OUT_W'(count);
  assign is_empty   = (count == '0);

endmodule

// File: src/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ple_ctrl.sv
// Sequencer for the positional list: clamps positions, moves entries one at a time.
module ple_ctrl #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ple_pkg::REQ_W-1:0]       req_type,
  input  logic [ple_pkg::POS_W-1:0]       position,
  input  logic [ple_pkg::DATA_W-1:0]      write_data,
  output logic                            ram_we,
  output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
  output logic [ple_pkg::DATA_W-1:0]      ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
  input  logic [ple_pkg::DATA_W-1:0]      ram_rdata,
  output logic                            done,
  output logic                            status,
  output logic [ple_pkg::DATA_W-1:0]      read_data,
  output logic                            read_valid,
  output logic [$clog2(CAPACITY+1)-1:0]   count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ple_pkg::CMP_W;

  ple_pkg::state_t state, state_next;

  logic [ple_pkg::REQ_W-1:0]  kind, kind_next;
  logic [ple_pkg::DATA_W-1:0] word, word_next;
  logic [AW-1:0]              tgt, tgt_next;
  logic [AW-1:0]              idx, idx_next;
  logic [CW-1:0]              count_next;
  logic                       done_next;
  logic                       status_next;
  logic [ple_pkg::DATA_W-1:0] read_data_next;
  logic                       read_valid_next;

  // Wide views for compares
  logic [XW-1:0] pos_x, cnt_x, idx_x, tgt_x, step_x;
  logic [XW-1:0] ins_p_x, del_p_x;
  logic          ins_ok, del_ok, rd_ok;
  logic          ins_more, del_more, move_more;

  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);
  assign idx_x = XW'(idx);
  assign tgt_x = XW'(tgt);

  // Request checks at accept time
  assign ins_ok  = cnt_x < XW'(CAPACITY);
  assign del_ok  = cnt_x != '0;
  assign rd_ok   = pos_x < cnt_x;
  assign ins_p_x = (pos_x > cnt_x) ? cnt_x : pos_x;
  assign del_p_x = (pos_x >= cnt_x) ? (cnt_x - XW'(1)) : pos_x;

  // Shifts needed right after accept
  assign ins_more = cnt_x > ins_p_x;
  assign del_more = (del_p_x + XW'(1)) < cnt_x;

  // Shared index unit: one step down for insert, one step up for delete
  assign step_x    = (kind == ple_pkg::REQ_INSERT) ? (idx_x - XW'(1)) : (idx_x + XW'(1));
  assign move_more = (kind == ple_pkg::REQ_INSERT) ? (step_x > tgt_x)
                                                   : ((step_x + XW'(1)) < cnt_x);

  assign busy = (state != ple_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::ST_IDLE: begin
        if (start) begin
          case (req_type)
            ple_pkg::REQ_INSERT: begin
              if (ins_ok) begin
                state_next = ins_more ? ple_pkg::ST_MOVE_RD : ple_pkg::ST_INS_WR;
              end
            end
            ple_pkg::REQ_DELETE: begin
              if (del_ok && del_more) begin
                state_next = ple_pkg::ST_MOVE_RD;
              end
            end
            ple_pkg::REQ_READ: begin
              if (rd_ok) begin
                state_next = ple_pkg::ST_READ;
              end
            end
            default: state_next = ple_pkg::ST_IDLE;
          endcase
        end
      end
      ple_pkg::ST_MOVE_RD: state_next = ple_pkg::ST_MOVE_WR;
      ple_pkg::ST_MOVE_WR: begin
        if (move_more) begin
          state_next = ple_pkg::ST_MOVE_RD;
        end else if (kind == ple_pkg::REQ_INSERT) begin
          state_next = ple_pkg::ST_INS_WR;
        end else begin
          state_next = ple_pkg::ST_IDLE;
        end
      end
      ple_pkg::ST_INS_WR: state_next = ple_pkg::ST_IDLE;
      ple_pkg::ST_READ:   state_next = ple_pkg::ST_IDLE;
      default:            state_next = ple_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and register next values
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = ram_rdata;
    ram_raddr       = AW'(step_x);
    kind_next       = kind;
    word_next       = word;
    tgt_next        = tgt;
    idx_next        = idx;
    count_next      = count;
    done_next       = 1'b0;
    status_next     = status;
    read_data_next  = read_data;
    read_valid_next = read_valid;
    case (state)
      ple_pkg::ST_IDLE: begin
        ram_raddr = AW'(pos_x);
        if (start) begin
          kind_next       = req_type;
          word_next       = write_data;
          read_data_next  = '0;
          read_valid_next = 1'b0;
          status_next     = ple_pkg::STAT_FAIL;
          case (req_type)
            ple_pkg::REQ_INSERT: begin
              tgt_next = AW'(ins_p_x);
              idx_next = AW'(cnt_x);
              // Full list: report at once
              done_next = !ins_ok;
            end
            ple_pkg::REQ_DELETE: begin
              tgt_next = AW'(del_p_x);
              idx_next = AW'(del_p_x);
              if (!del_ok) begin
                done_next = 1'b1;
              end else if (!del_more) begin
                // Last entry removed, nothing to close up
                count_next  = count - CW'(1);
                status_next = ple_pkg::STAT_OK;
                done_next   = 1'b1;
              end
            end
            ple_pkg::REQ_READ: begin
              done_next = !rd_ok;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ple_pkg::ST_MOVE_WR: begin
        // Copy the neighbor read last cycle into the current slot
        ram_we   = 1'b1;
        idx_next = AW'(step_x);
        if (!move_more && kind != ple_pkg::REQ_INSERT) begin
          count_next  = count - CW'(1);
          status_next = ple_pkg::STAT_OK;
          done_next   = 1'b1;
        end
      end
      ple_pkg::ST_INS_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = tgt;
        ram_wdata   = word;
        count_next  = count + CW'(1);
        status_next = ple_pkg::STAT_OK;
        done_next   = 1'b1;
      end
      ple_pkg::ST_READ: begin
        read_data_next  = ram_rdata;
        read_valid_next = 1'b1;
        status_next     = ple_pkg::STAT_OK;
        done_next       = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    word       <= word_next;
    tgt        <= tgt_next;
    idx        <= idx_next;
    status     <= status_next;
    read_data  <= read_data_next;
    read_valid <= read_valid_next;
  end

endmodule
